// File: design/prex_pkg.sv
// Shared types and constants for the printable run extractor.
package prex_pkg;

	// Item kind codes
	localparam logic KIND_RUNE = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	localparam int RUNE_W = 21;
	localparam int OFFS_W = 32;
	localparam int SPAN_W = 6;

	localparam logic [SPAN_W-1:0] MIN_SPAN_RST = 6'd6;

	// Printable ranges: 0x20..0x7E, and anything above 0xA0
	localparam logic [RUNE_W-1:0] PRINT_LO  = 21'h00020;
	localparam logic [RUNE_W-1:0] PRINT_DEL = 21'h0007F;
	localparam logic [RUNE_W-1:0] PRINT_HI  = 21'h000A0;

	typedef struct packed {
		logic              kind;
		logic [RUNE_W-1:0] rune_value;
		logic [OFFS_W-1:0] byte_offset;
	} item_t;

	typedef struct packed {
		logic [OFFS_W-1:0] run_start;
		logic [RUNE_W-1:0] run_rune;
		logic              truncated;
		logic              last;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic take;  // input item accepted
		logic rd;    // read the buffer at the replay index
		logic step;  // result taken, advance the replay index
	} prex_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic emit;  // accepted item starts a replay
		logic last;  // replay index is at the final rune
	} prex_sts_t;

endpackage

// File: design/prex_ctrl.sv
// Controller state machine: accept items, sequence the buffer replay.
module prex_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  prex_pkg::prex_sts_t sts,
	output prex_pkg::prex_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_SHOW = 3'b100
	} state_t;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		item_stall   = 1'b1;
		result_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.take = 1'b1;
					if (sts.emit) state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_SHOW;
			end
			ST_SHOW: begin
				result_valid = 1'b1;
				if (!result_stall) begin
					if (sts.last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.step = 1'b1;
						state_d  = ST_READ;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: design/prex_dp.sv
// Datapath: run buffer memory, run count and origin, replay registers.
module prex_dp #(
	parameter int RUN_LIMIT = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [prex_pkg::SPAN_W-1:0]        min_span,
	input  prex_pkg::item_t                    item,
	output prex_pkg::result_t                  result,
	input  prex_pkg::prex_cmd_t                cmd,
	output prex_pkg::prex_sts_t                sts
);

	localparam int CW = $clog2(RUN_LIMIT + 1);
	localparam int AW = $clog2(RUN_LIMIT);
	localparam int MW = (CW > prex_pkg::SPAN_W) ? CW : prex_pkg::SPAN_W;

	logic [prex_pkg::RUNE_W-1:0] mem [RUN_LIMIT];

	logic [prex_pkg::SPAN_W-1:0] min_span_q;
	logic [CW-1:0]               count_q;
	logic                        active_q;
	logic [prex_pkg::OFFS_W-1:0] origin_q;
	logic [CW-1:0]               len_q;
	logic [AW-1:0]               idx_q;
	logic                        trunc_q;
	logic [prex_pkg::RUNE_W-1:0] rd_data_q;

	logic          printable;
	logic          closing;
	logic [CW-1:0] count_next;
	logic          hit_limit;
	logic          span_ok;

	// Classify the incoming item
	always_comb begin
		printable = ((item.rune_value >= prex_pkg::PRINT_LO) &&
			(item.rune_value < prex_pkg::PRINT_DEL)) ||
			(item.rune_value > prex_pkg::PRINT_HI);
		closing    = (item.kind == prex_pkg::KIND_EOS) || !printable;
		count_next = count_q + CW'(1);
		hit_limit  = (count_next == CW'(RUN_LIMIT));
		span_ok    = (MW'(count_q) >= MW'(min_span_q)) && (count_q != '0);
		sts.emit   = closing ? span_ok : hit_limit;
		sts.last   = ((CW'(idx_q) + CW'(1)) == len_q);
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_span_q <= prex_pkg::MIN_SPAN_RST;
		end else if (cfg_we) begin
			min_span_q <= min_span;
		end
	end

	// Run tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			active_q <= 1'b0;
		end else if (cmd.take) begin
			if (closing || hit_limit) begin
				count_q  <= '0;
				active_q <= 1'b0;
			end else begin
				count_q  <= count_next;
				active_q <= 1'b1;
			end
		end
	end

	// Run origin, replay length and flag
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (!closing && !active_q) origin_q <= item.byte_offset;
			if (sts.emit) begin
				len_q   <= closing ? count_q : count_next;
				trunc_q <= !closing;
			end
		end
	end

	// Replay index
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// Run buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.take && !closing) mem[count_q[AW-1:0]] <= item.rune_value;
		if (cmd.rd) rd_data_q <= mem[idx_q];
	end

	assign result.run_start = origin_q;
	assign result.run_rune  = rd_data_q;
	assign result.truncated = trunc_q;
	assign result.last      = sts.last;

endmodule

// File: design/printable_run_extractor_unit.sv
// Flow: a rune that extends a run is taken with no result.
// An item that ends a reportable run gives its first result after the READ
// and SHOW states (buffer read, output reg); each following rune passes through READ and SHOW again.
// The next item is accepted the cycle after the final rune is taken.
// Reset (arst_n low, async): no run open, count zero, min_span back to 6;
// the run buffer is not cleared.
module printable_run_extractor_unit #(
	parameter int RUN_LIMIT = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [prex_pkg::SPAN_W-1:0] min_span,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  prex_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output prex_pkg::result_t           result
);

	prex_pkg::prex_cmd_t cmd;
	prex_pkg::prex_sts_t sts;

	// Sequencer
	prex_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// Buffer and run state
	prex_dp #(
		.RUN_LIMIT (RUN_LIMIT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.min_span (min_span),
		.item     (item),
		.result   (result),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// File: design/prex_checker.sv
// Port-level checker for the printable run extractor, with its bind.
module prex_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input prex_pkg::result_t result
);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// No item is taken while a run is being replayed
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("item accepted during replay");

	// An accepted item never shows a result in the very next cycle
	a_take_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !result_valid)
		else $error("result right after item accept");

	// Next rune of the same run follows after a fresh buffer read with same start
	a_same_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.last |-> ##2
		(result_valid && result.run_start == $past(result.run_start, 2) &&
		result.truncated == $past(result.truncated, 2)))
		else $error("run broken mid replay");

	// Replay ends after the final rune
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.last |=> !result_valid)
		else $error("result after final rune");

endmodule

bind printable_run_extractor_unit prex_checker u_prex_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: dv/prex_run_checker.sv
// Checker for the printable run extractor: tracks runs, predicts emitted runes, compares results.
`timescale 1ns / 100ps
module prex_run_checker
	import prex_pkg::*;
#(
	parameter int RUN_LIMIT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SPAN_W-1:0] min_span,
	input  logic              item_valid,
	input  logic              item_stall,
	input  item_t             item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  result_t           result,
	output int                fail_count,
	output int                runes_due
);

	// Shadow of the block's run state and register
	logic [RUNE_W-1:0] run_buf [RUN_LIMIT];
	int                run_len;
	logic [OFFS_W-1:0] run_origin_q;
	logic              run_open;
	logic [SPAN_W-1:0] span_q;
	result_t           due_q [$];
	result_t           want;

	initial fail_count = 0;

	function automatic bit is_printable(input logic [RUNE_W-1:0] r);
		return (r >= PRINT_LO && r < PRINT_DEL) || r > PRINT_HI;
	endfunction

	// Queue every buffered rune of the run, then start over with no run open
	function automatic void flush_run(input logic trunc);
		for (int k = 0; k < run_len; k++)
			due_q.push_back(result_t'{run_origin_q, run_buf[k], trunc, k == run_len - 1});
		run_len = 0;
		run_open = 1'b0;
	endfunction

	// Run tracking for one accepted item
	function automatic void take_item(input item_t it);
		if (it.kind == KIND_EOS || !is_printable(it.rune_value)) begin
			// run too short: drop it silently
			if (run_len < int'(span_q))
				run_len = 0;
			flush_run(1'b0);
		end else begin
			// open flag, not a zero origin, marks a live run
			if (!run_open) begin
				run_open = 1'b1;
				run_origin_q = it.byte_offset;
			end
			run_buf[run_len] = it.rune_value;
			run_len++;
			if (run_len >= RUN_LIMIT)
				flush_run(1'b1);
		end
	endfunction

	task automatic report_field(input string name, input logic [OFFS_W-1:0] exp_v,
			input logic [OFFS_W-1:0] got_v);
		fail_count++;
		$display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
	endtask

	// Sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len = 0;
			run_open = 1'b0;
			run_origin_q = '0;
			span_q = MIN_SPAN_RST;
			due_q.delete();
		end else begin
			if (cfg_we)
				span_q = min_span;
			if (item_valid && !item_stall)
				take_item(item);
			if (result_valid && !result_stall) begin
				if (due_q.size() == 0) begin
					fail_count++;
					$display("%0t: result expected none got %h", $time, result);
				end else begin
					want = due_q.pop_front();
					if (result.run_start !== want.run_start)
						report_field("run_start", want.run_start, result.run_start);
					if (result.run_rune !== want.run_rune)
						report_field("run_rune", OFFS_W'(want.run_rune),
							OFFS_W'(result.run_rune));
					if (result.truncated !== want.truncated)
						report_field("truncated", OFFS_W'(want.truncated),
							OFFS_W'(result.truncated));
					if (result.last !== want.last)
						report_field("last", OFFS_W'(want.last), OFFS_W'(result.last));
				end
			end
		end
		runes_due = due_q.size();
	end

endmodule

// File: dv/tb_printable_run_extractor_unit.sv
// Testbench top for the printable run extractor: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_printable_run_extractor_unit;
	import prex_pkg::*;

	localparam int RUN_LIMIT     = 64;
	localparam int SETTLE_CYCLES = 8;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [SPAN_W-1:0] min_span;
	logic              item_valid;
	logic              item_stall;
	item_t             item;
	logic              result_valid;
	logic              result_stall;
	result_t           result;
	int                fail_count;
	int                runes_due;

	int                send_gap_pct;
	int                recv_stall_pct;
	int                items_sent;
	logic [OFFS_W-1:0] offs_cursor;

	printable_run_extractor_unit #(.RUN_LIMIT(RUN_LIMIT)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.min_span     (min_span),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	prex_run_checker #(.RUN_LIMIT(RUN_LIMIT)) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.min_span     (min_span),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.runes_due    (runes_due)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Receiver backpressure
	always @(negedge clk)
		result_stall <= ($urandom_range(99) < recv_stall_pct);

	// Hang guard
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [RUNE_W-1:0] pick_printable();
		case ($urandom_range(2))
			0: return RUNE_W'($urandom_range(PRINT_DEL - 1, PRINT_LO));
			1: return RUNE_W'($urandom_range(21'h0FFFF, PRINT_HI + 1));
			default: return RUNE_W'($urandom_range(21'h1FFFFF, PRINT_HI + 1));
		endcase
	endfunction

	// Control range or the DEL..NBSP gap
	function automatic logic [RUNE_W-1:0] pick_unprintable();
		if ($urandom_range(1))
			return RUNE_W'($urandom_range(PRINT_LO - 1, 0));
		return RUNE_W'($urandom_range(PRINT_HI, PRINT_DEL));
	endfunction

	// Present one item after optional gaps; hold it until accepted
	task automatic send_item(input logic k, input logic [RUNE_W-1:0] r,
			input logic [OFFS_W-1:0] offs);
		while ($urandom_range(99) < send_gap_pct) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= item_t'{k, r, offs};
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic send_rune(input logic [RUNE_W-1:0] r);
		send_item(KIND_RUNE, r, offs_cursor);
		offs_cursor += $urandom_range(4, 1);
	endtask

	task automatic go_idle();
		@(negedge clk);
		item_valid <= 1'b0;
	endtask

	// Drain everything, let the block settle, then write min_span
	task automatic set_span(input logic [SPAN_W-1:0] v);
		go_idle();
		while (runes_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		min_span <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Runs of random length around min_span or near RUN_LIMIT, closed by an unprintable rune or end of stream,
	// with some noise items mixed in
	task automatic random_burst(input int quota);
		int len;
		int span;
		int pick;
		int lo;
		int hi;
		bit first;
		first = 1'b1;
		span = int'(min_span);
		items_sent = 0;
		while (items_sent < quota) begin
			case ($urandom_range(9))
				0: offs_cursor = $urandom();
				1: offs_cursor = '0;
				2: offs_cursor = 32'hFFFF_FFF0;
				default: ;
			endcase
			pick = $urandom_range(99);
			if (first || pick >= 85) begin
				len = $urandom_range(RUN_LIMIT + 6, RUN_LIMIT - 4);
			end else if (pick < 10) begin
				len = -1;
			end else if (pick < 30) begin
				len = $urandom_range(span > 0 ? span - 1 : 0, 0);
			end else begin
				lo = span > 2 ? span - 2 : 0;
				hi = span + 2;
				len = $urandom_range(hi, lo);
			end
			first = 1'b0;
			if (len < 0) begin
				send_item(1'($urandom_range(1)), RUNE_W'($urandom()), $urandom());
			end else begin
				repeat (len) send_rune(pick_printable());
				if ($urandom_range(9) < 7)
					send_rune(pick_unprintable());
				else
					send_item(KIND_EOS, RUNE_W'($urandom()), $urandom());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		min_span = MIN_SPAN_RST;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		send_gap_pct = 8;
		recv_stall_pct = 60;
		offs_cursor = '0;
		items_sent = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, min_span at reset value
		send_item(KIND_EOS, 21'h1FFFFF, 32'hFFFF_FFFF);
		// run starting at offset zero, range edges of printable
		offs_cursor = '0;
		send_rune(PRINT_LO);
		send_rune(PRINT_DEL - 1);
		send_rune(PRINT_HI + 1);
		send_rune(21'h10FFFF);
		send_rune(21'h1FFFFF);
		send_rune(21'h61);
		send_rune(21'h62);
		send_item(KIND_RUNE, PRINT_DEL, 32'h0000_0100);
		send_item(KIND_RUNE, PRINT_LO - 1, 32'h0000_0101);
		send_item(KIND_RUNE, PRINT_HI, 32'h0000_0102);
		// exactly min_span runes across the offset wrap, closed by end of stream
		offs_cursor = 32'hFFFF_FFFA;
		repeat (6) send_rune(pick_printable());
		send_item(KIND_EOS, 21'h1FFFFF, '0);
		// short run is dropped
		offs_cursor = 32'h1234_0000;
		repeat (3) send_rune(pick_printable());
		send_item(KIND_RUNE, '0, offs_cursor);

		// min_span zero: empty close gives nothing, one rune is reported
		set_span('0);
		send_item(KIND_EOS, '0, '0);
		send_item(KIND_RUNE, 21'h5A, '0);
		send_item(KIND_EOS, '0, 32'h1);
		send_item(KIND_RUNE, 21'h1F, '0);

		// Sender idles lightly, receiver heavily
		set_span(6'd1);
		random_burst(50);

		// Receiver idles lightly, sender heavily; only long runs report
		send_gap_pct = 60;
		recv_stall_pct = 8;
		set_span(6'd63);
		random_burst(80);

		// No idling
		send_gap_pct = 0;
		recv_stall_pct = 0;
		set_span(SPAN_W'($urandom_range(12, 2)));
		random_burst(45);

		go_idle();
		while (runes_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && runes_due == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
